[sv/ctis_pkg.sv]
// Package with shared constants, types and functions for the frame transform.
`timescale 1ns / 1ps
package ctis_pkg;

  localparam int CordicStagesDef = 24;
  localparam int FracBitsDef = 24;
  localparam int InW = 32;
  localparam int OutW = 48;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;
  localparam logic [31:0] GainQ32 = 32'd2608131497;

  localparam logic [CfgIdxW-1:0] RegLengthScale = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegVelocityScale = CfgIdxW'(1);

  typedef logic [31:0] turn_t;

  function automatic turn_t atan_turn(input int i);
    turn_t t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic signed [InW-1:0] px;
    logic signed [InW-1:0] py;
    logic signed [InW-1:0] pz;
    logic signed [InW-1:0] vx;
    logic signed [InW-1:0] vy;
    logic signed [InW-1:0] vz;
  } vec_t;

  typedef struct packed {
    logic signed [InW-1:0] pos_x;
    logic signed [InW-1:0] pos_y;
    logic signed [InW-1:0] pos_z;
    logic signed [InW-1:0] vel_x;
    logic signed [InW-1:0] vel_y;
    logic signed [InW-1:0] vel_z;
    turn_t phase;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_pos_x;
    logic signed [OutW-1:0] out_pos_y;
    logic signed [OutW-1:0] out_pos_z;
    logic signed [OutW-1:0] out_vel_x;
    logic signed [OutW-1:0] out_vel_y;
    logic signed [OutW-1:0] out_vel_z;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] val;
  } cfg_item_t;

endpackage

[sv/ctis_if.sv]
// Valid/ready channel interface with a generic payload.
`timescale 1ns / 1ps
interface ctis_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/ctis_cell.sv]
// One CORDIC rotation cell that also carries the state vector along.
`timescale 1ns / 1ps
module ctis_cell #(
  parameter int Idx = 0,
  parameter int XW = 32
) (
  input  logic clk,
  input  logic en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [32:0] z_i,
  input  logic [1:0] q_i,
  input  ctis_pkg::vec_t v_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [32:0] z_o,
  output logic [1:0] q_o,
  output ctis_pkg::vec_t v_o
);
  logic signed [XW-1:0] dx, dy;
  logic signed [32:0] at;
  assign dx = y_i >>> Idx;
  assign dy = x_i >>> Idx;
  assign at = $signed({1'b0, ctis_pkg::atan_turn(Idx)});
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[32]) begin
        x_o <= x_i - dx; y_o <= y_i + dy; z_o <= z_i - at;
      end else begin
        x_o <= x_i + dx; y_o <= y_i - dy; z_o <= z_i + at;
      end
      q_o <= q_i;
      v_o <= v_i;
    end
  end
endmodule

[sv/ctis_scale.sv]
// Signed-magnitude scaling by a Q16.16 register with rounding and clamp.
`timescale 1ns / 1ps
module ctis_scale (
  input  logic clk,
  input  logic en,
  input  logic signed [39:0] v_i,
  input  logic [31:0] k_i,
  output logic signed [ctis_pkg::OutW-1:0] r_o,
  output logic sat_o
);
  logic neg_r;
  logic [39:0] m;
  logic [71:0] p_r;
  logic [72:0] r;
  assign m = v_i[39] ? 40'(-v_i) : 40'(v_i);
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= v_i[39];
      p_r <= 72'(m) * 72'(k_i);
    end
  end
  always_comb begin
    r = (73'(p_r) + 73'(1 << 23)) >> 24;
    sat_o = 1'b0;
    if (!neg_r && r > 73'h7FFFFFFFFFFF) begin
      r = 73'h7FFFFFFFFFFF; sat_o = 1'b1;
    end
    if (neg_r && r > 73'h800000000000) begin
      r = 73'h800000000000; sat_o = 1'b1;
    end
    r_o = neg_r ? ctis_pkg::OutW'(-r) : ctis_pkg::OutW'(r);
  end
endmodule

[sv/corotating_to_inertial_state.sv]
// Top level: co-rotating to inertial state transform with dimensional scaling.
// Channels: in_ carries a normalized position, velocity and phase; out_ carries
// the scaled inertial position and velocity and a saturation flag; cfg_ writes
// length_scale (index 0) and velocity_scale (index 1). Each transfer completes
// when valid and ready are both high at a rising edge.
// Throughput is one item per cycle while out_ is not stalled. The pipeline
// is one rotation cell per CORDIC stage, a quadrant stage, a rotation
// multiply stage, a round stage and the scaling multiply stage, whose
// register also serves as the output register.
// The whole pipeline advances only when the output register is empty or is
// being taken, so a stall at out_ freezes every stage and deasserts in_ready;
// nothing is lost. Reset clears all valid flags and sets both scale
// registers to 1.0.
`timescale 1ns / 1ps
module corotating_to_inertial_state #(
  parameter int CORDIC_STAGES = ctis_pkg::CordicStagesDef,
  parameter int FRAC_BITS = ctis_pkg::FracBitsDef
) (
  input logic clk,
  input logic rst_n,
  ctis_if.sink in_ch,
  ctis_if.source out_ch,
  ctis_if.sink cfg_ch
);
  localparam int XW = FRAC_BITS + 4;
  localparam int NS = CORDIC_STAGES;
  localparam int Lat = NS + 4;

  logic [31:0] length_scale_r, velocity_scale_r;
  logic [Lat-1:0] vld_r;
  logic en;
  logic out_valid_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_scale_r <= 32'd65536;
      velocity_scale_r <= 32'd65536;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.idx == ctis_pkg::RegLengthScale) length_scale_r <= cfg_ch.data.val;
      if (cfg_ch.data.idx == ctis_pkg::RegVelocityScale) velocity_scale_r <= cfg_ch.data.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end
  assign out_valid_r = vld_r[Lat-1];
  assign out_ch.valid = out_valid_r;

  // Phase split into quadrant and residual.
  logic [31:0] ph, qsum, resid;
  logic [1:0] q0;
  ctis_pkg::vec_t v0;
  assign ph = in_ch.data.phase;
  assign qsum = ph + 32'h20000000;
  assign q0 = qsum[31:30];
  assign resid = ph - {q0, 30'd0};
  assign v0.px = in_ch.data.pos_x; assign v0.py = in_ch.data.pos_y;
  assign v0.pz = in_ch.data.pos_z; assign v0.vx = in_ch.data.vel_x;
  assign v0.vy = in_ch.data.vel_y; assign v0.vz = in_ch.data.vel_z;

  localparam logic [32:0] GainR = (33'(ctis_pkg::GainQ32) + (33'd1 << (31 - FRAC_BITS)))
      >> (32 - FRAC_BITS);

  logic signed [XW-1:0] xs [NS+1];
  logic signed [XW-1:0] ys [NS+1];
  logic signed [32:0] zs [NS+1];
  logic [1:0] qs [NS+1];
  ctis_pkg::vec_t vs [NS+1];
  assign xs[0] = XW'(GainR);
  assign ys[0] = '0;
  assign zs[0] = $signed({resid[31], resid});
  assign qs[0] = q0;
  assign vs[0] = v0;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    ctis_cell #(.Idx(g), .XW(XW)) u_cell (
      .clk(clk), .en(en),
      .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]), .q_i(qs[g]), .v_i(vs[g]),
      .x_o(xs[g+1]), .y_o(ys[g+1]), .z_o(zs[g+1]), .q_o(qs[g+1]), .v_o(vs[g+1])
    );
  end

  // Quadrant correction and velocity frame terms.
  logic signed [XW-1:0] c_r, s_r;
  logic signed [32:0] a_r, b_r;
  ctis_pkg::vec_t vq_r;
  logic signed [XW-1:0] xe, ye;
  assign xe = xs[NS];
  assign ye = ys[NS];
  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[NS])
        2'd0: begin c_r <= xe; s_r <= ye; end
        2'd1: begin c_r <= -ye; s_r <= xe; end
        2'd2: begin c_r <= -xe; s_r <= -ye; end
        default: begin c_r <= ye; s_r <= -xe; end
      endcase
      a_r <= 33'(vs[NS].vx) - 33'(vs[NS].py);
      b_r <= 33'(vs[NS].vy) + 33'(vs[NS].px);
      vq_r <= vs[NS];
    end
  end

  // Products.
  localparam int PW = XW + 33;
  logic signed [PW-1:0] cpx_r, spy_r, spx_r, cpy_r, ca_r, sb_r, sa_r, cb_r;
  logic signed [31:0] pz2_r, vz2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cpx_r <= PW'(c_r) * PW'(vq_r.px); spy_r <= PW'(s_r) * PW'(vq_r.py);
      spx_r <= PW'(s_r) * PW'(vq_r.px); cpy_r <= PW'(c_r) * PW'(vq_r.py);
      ca_r <= PW'(c_r) * PW'(a_r); sb_r <= PW'(s_r) * PW'(b_r);
      sa_r <= PW'(s_r) * PW'(a_r); cb_r <= PW'(c_r) * PW'(b_r);
      pz2_r <= vq_r.pz; vz2_r <= vq_r.vz;
    end
  end

  // Sum and round to Q16.24.
  localparam logic signed [PW:0] Half = (PW+1)'(1) <<< (FRAC_BITS - 1);
  logic signed [PW:0] sx, sy, tx, ty;
  logic signed [39:0] rpx_r, rpy_r, rvx_r, rvy_r, pz3_r, vz3_r;
  assign sx = (PW+1)'(cpx_r) - (PW+1)'(spy_r) + Half;
  assign sy = (PW+1)'(spx_r) + (PW+1)'(cpy_r) + Half;
  assign tx = (PW+1)'(ca_r) - (PW+1)'(sb_r) + Half;
  assign ty = (PW+1)'(sa_r) + (PW+1)'(cb_r) + Half;
  always_ff @(posedge clk) begin
    if (en) begin
      rpx_r <= 40'(sx >>> FRAC_BITS); rpy_r <= 40'(sy >>> FRAC_BITS);
      rvx_r <= 40'(tx >>> FRAC_BITS); rvy_r <= 40'(ty >>> FRAC_BITS);
      pz3_r <= 40'(pz2_r); vz3_r <= 40'(vz2_r);
    end
  end

  logic signed [ctis_pkg::OutW-1:0] o [6];
  logic [5:0] sat;
  logic signed [39:0] sv_in [6];
  logic [31:0] sk [6];
  assign sv_in[0] = rpx_r; assign sv_in[1] = rpy_r; assign sv_in[2] = pz3_r;
  assign sv_in[3] = rvx_r; assign sv_in[4] = rvy_r; assign sv_in[5] = vz3_r;
  assign sk[0] = length_scale_r; assign sk[1] = length_scale_r;
  assign sk[2] = length_scale_r; assign sk[3] = velocity_scale_r;
  assign sk[4] = velocity_scale_r; assign sk[5] = velocity_scale_r;
  for (genvar g = 0; g < 6; g++) begin : g_scale
    ctis_scale u_scale (.clk(clk), .en(en), .v_i(sv_in[g]), .k_i(sk[g]),
      .r_o(o[g]), .sat_o(sat[g]));
  end

  assign out_ch.data.out_pos_x = o[0];
  assign out_ch.data.out_pos_y = o[1];
  assign out_ch.data.out_pos_z = o[2];
  assign out_ch.data.out_vel_x = o[3];
  assign out_ch.data.out_vel_y = o[4];
  assign out_ch.data.out_vel_z = o[5];
  assign out_ch.data.saturated = |sat;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  a_no_in_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline frozen");
  a_cfg_len: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.data.idx == ctis_pkg::RegLengthScale
    |=> length_scale_r == $past(cfg_ch.data.val))
    else $error("length scale not written");
endmodule
